/* sv/tvws_pkg.sv */
// Shared types, constants and the sine lookup for the three-voice wavetable sequencer.
// No dependencies; every other file refers to this package by scoped names.
package tvws_pkg;

    localparam int POS_W      = 6;
    localparam int WAVE_W     = 5;
    localparam int PERIOD_W   = 32;
    localparam int SAMPLE_W   = 13;
    localparam int FUNC_W     = 3;
    localparam int VOICE_W    = 2;
    localparam int NUM_VOICES = 3;
    localparam int SUM_W      = 14;   // three sine values of up to 4096
    localparam int CNT_W      = 2;

    // divide by three: floor(sum * 43691 / 2^17) is exact for sum <= 12288
    localparam int            RECIP_SHIFT = 17;
    localparam logic [16:0]   RECIP_THREE = 17'd43691;
    localparam int            PROD_W      = SUM_W + RECIP_SHIFT;

    localparam logic [FUNC_W-1:0] FUNC_STEP  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_PLAY  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_PAUSE = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_STOP  = 3'd5;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_RELOAD = 1'b1;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 13'd4096;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [VOICE_W-1:0]  voice;
        logic [POS_W-1:0]    entry_index;
        logic [PERIOD_W-1:0] period_one;
        logic [PERIOD_W-1:0] period_two;
        logic [PERIOD_W-1:0] period_three;
    } req_t;

    typedef struct packed {
        logic                result_kind;
        logic [SAMPLE_W-1:0] sample;
        logic [PERIOD_W-1:0] reload_one;
        logic [PERIOD_W-1:0] reload_two;
        logic [PERIOD_W-1:0] reload_three;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic step_adv;
        logic step_wrap;
        logic tick;
        logic write_entry;
        logic play;
        logic pause;
        logic stop;
        logic mix;
        logic out_load;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              voice_ok;
        logic              playing;
        logic              pos_below_len;
        logic              out_free;
    } sts_t;

    function automatic logic [SAMPLE_W-1:0] sine_value(input logic [WAVE_W-1:0] idx);
        logic [SAMPLE_W-1:0] v;
        case (idx)
            5'd0:    v = 13'd2048;
            5'd1:    v = 13'd2448;
            5'd2:    v = 13'd2832;
            5'd3:    v = 13'd3186;
            5'd4:    v = 13'd3496;
            5'd5:    v = 13'd3751;
            5'd6:    v = 13'd3940;
            5'd7:    v = 13'd4057;
            5'd8:    v = 13'd4096;
            5'd9:    v = 13'd4057;
            5'd10:   v = 13'd3940;
            5'd11:   v = 13'd3751;
            5'd12:   v = 13'd3496;
            5'd13:   v = 13'd3186;
            5'd14:   v = 13'd2832;
            5'd15:   v = 13'd2448;
            5'd16:   v = 13'd2048;
            5'd17:   v = 13'd1648;
            5'd18:   v = 13'd1264;
            5'd19:   v = 13'd910;
            5'd20:   v = 13'd600;
            5'd21:   v = 13'd345;
            5'd22:   v = 13'd156;
            5'd23:   v = 13'd39;
            5'd24:   v = 13'd0;
            5'd25:   v = 13'd39;
            5'd26:   v = 13'd156;
            5'd27:   v = 13'd345;
            5'd28:   v = 13'd600;
            5'd29:   v = 13'd910;
            5'd30:   v = 13'd1264;
            5'd31:   v = 13'd1648;
            default: v = 13'd0;
        endcase
        return v;
    endfunction

endpackage

/* sv/three_voice_wavetable_sequencer_unit.sv */
// Top level of the three-voice wavetable sequencer: controller plus datapath.
// Depends on tvws_pkg, tvws_ctrl and tvws_datapath.
//
// One request at a time. A request is taken when req_valid is high and req_stall low;
// the block then stalls until it has executed it. Requests that give no result (table
// write, play, pause, stop, a tick to a voice out of range, a song step while paused
// or at the wrap, and unknown codes) go through capture and execute. A voice tick or
// a song step that advances goes through capture, execute with the song table read
// issued, the registered read plus voice summation, and the averaging multiply that
// loads the output register. The song table is a single-port memory with a registered
// read, which adds the read step; averaging over three voices is a reciprocal
// multiply with its own step. The result sits in an output register, so a new
// request is taken while a finished result waits on rsp_stall; only a second
// result then waits in the mix step until the first is taken. The song table
// starts all zero after reset through a valid bit per entry, so no clearing pass
// is needed. SONG_DEPTH sets the table size; positions at or beyond it read as
// zero and writes there are dropped. song_length is written through cfg_we and
// cfg_data, by the user only while the block is idle; the block does not enforce it.
module three_voice_wavetable_sequencer_unit
#(
    parameter int SONG_DEPTH = 64
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // song_length register
    input  logic                          cfg_we,
    input  logic [tvws_pkg::POS_W-1:0]    cfg_data,
    // request channel
    input  logic                          req_valid,
    output logic                          req_stall,
    input  tvws_pkg::req_t                req,
    // result channel
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output tvws_pkg::rsp_t                rsp
);

    tvws_pkg::cmd_t cmd;
    tvws_pkg::sts_t sts;

    tvws_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    tvws_datapath
    #(
        .SONG_DEPTH (SONG_DEPTH)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // a taken request keeps the block busy for the following cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request accepted while block not busy next cycle");

    // controller never issues two commands at once
    a_single_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command");

    // a new result only appears after a load command
    a_rsp_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(cmd.out_load))
        else $error("result valid without load");

    // a reload result carries no sample
    a_reload_no_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.result_kind == tvws_pkg::KIND_RELOAD)) |-> (rsp.sample == '0))
        else $error("reload result with nonzero sample");

    // averaged sample never exceeds the sine peak
    a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.sample <= tvws_pkg::SAMPLE_MAX))
        else $error("sample above sine peak");

endmodule

/* sv/tvws_ctrl.sv */
// Sequencing state machine: takes a request, issues datapath commands, waits on status.
// Depends on tvws_pkg (cmd_t, sts_t, function codes).
module tvws_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    output tvws_pkg::cmd_t   cmd,
    input  tvws_pkg::sts_t   sts
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_MIX  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                case (sts.func)
                    tvws_pkg::FUNC_STEP:
                    begin
                        if (sts.playing)
                        begin
                            if (sts.pos_below_len)
                            begin
                                cmd.step_adv = 1'b1;
                                state_next   = S_READ;
                            end
                            else
                            begin
                                cmd.step_wrap = 1'b1;
                            end
                        end
                    end
                    tvws_pkg::FUNC_TICK:
                    begin
                        if (sts.voice_ok)
                        begin
                            cmd.tick   = 1'b1;
                            state_next = S_READ;
                        end
                    end
                    tvws_pkg::FUNC_WRITE: cmd.write_entry = 1'b1;
                    tvws_pkg::FUNC_PLAY:  cmd.play        = 1'b1;
                    tvws_pkg::FUNC_PAUSE: cmd.pause       = 1'b1;
                    tvws_pkg::FUNC_STOP:  cmd.stop        = 1'b1;
                    default:              state_next      = S_IDLE;
                endcase
            end
            S_READ:
            begin
                cmd.mix    = 1'b1;
                state_next = S_MIX;
            end
            S_MIX:
            begin
                // hold until the output register can take the result
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* sv/tvws_datapath.sv */
// Datapath: request register, song table memory, voice state, mixer and output register.
// Depends on tvws_pkg (types, constants, sine lookup).
module tvws_datapath
#(
    parameter int SONG_DEPTH = 64
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tvws_pkg::POS_W-1:0]    cfg_data,
    input  tvws_pkg::req_t                req,
    output tvws_pkg::rsp_t                rsp,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    input  tvws_pkg::cmd_t                cmd,
    output tvws_pkg::sts_t                sts
);

    localparam int POS_W    = tvws_pkg::POS_W;
    localparam int PERIOD_W = tvws_pkg::PERIOD_W;
    localparam int NV       = tvws_pkg::NUM_VOICES;
    localparam int SUM_W    = tvws_pkg::SUM_W;
    // only 2^POS_W positions are addressable, deeper entries would never be used
    localparam int MEM_DEPTH = (SONG_DEPTH < (2 ** POS_W)) ? SONG_DEPTH : (2 ** POS_W);
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int MEM_W     = NV * PERIOD_W;

    tvws_pkg::req_t                 req_reg;
    logic [POS_W-1:0]               song_len_reg;
    logic                           playing_reg, playing_next;
    logic [POS_W-1:0]               song_pos_reg, song_pos_next;
    logic [tvws_pkg::WAVE_W-1:0]    wave_pos_reg [NV];
    logic [tvws_pkg::WAVE_W-1:0]    wave_pos_next [NV];

    logic [MEM_W-1:0]               song_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0]           valid_reg;
    logic [MEM_W-1:0]               rd_data_reg;
    logic                           rd_hit_reg;
    logic                           kind_reg;

    logic [SUM_W-1:0]               sum_reg, sum_next;
    logic [tvws_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic                           mute_reg;

    tvws_pkg::rsp_t                 rsp_reg, rsp_next;
    logic                           rsp_valid_reg, rsp_valid_next;

    logic [POS_W-1:0]               pos_inc;
    logic [POS_W-1:0]               rd_pos;
    logic                           rd_in_range, wr_in_range, rd_en;
    logic [ADDR_W-1:0]              rd_idx, wr_idx;
    logic [PERIOD_W-1:0]            entry_period [NV];
    logic [tvws_pkg::PROD_W-1:0]    prod;
    logic [SUM_W-1:0]               quot;
    logic                           out_free;

    assign pos_inc     = song_pos_reg + POS_W'(1);
    assign rd_pos      = cmd.step_adv ? pos_inc : song_pos_reg;
    assign rd_in_range = {1'b0, rd_pos} < (POS_W + 1)'(MEM_DEPTH);
    assign wr_in_range = {1'b0, req_reg.entry_index} < (POS_W + 1)'(MEM_DEPTH);
    assign rd_idx      = rd_pos[ADDR_W-1:0];
    assign wr_idx      = req_reg.entry_index[ADDR_W-1:0];
    assign rd_en       = cmd.step_adv | cmd.tick;
    assign out_free    = !rsp_valid_reg || !rsp_stall;

    assign sts.func          = req_reg.func;
    assign sts.voice_ok      = req_reg.voice < tvws_pkg::VOICE_W'(NV);
    assign sts.playing       = playing_reg;
    assign sts.pos_below_len = song_pos_reg < song_len_reg;
    assign sts.out_free      = out_free;

    // voice and song state updates
    always_comb
    begin
        playing_next  = playing_reg;
        song_pos_next = song_pos_reg;
        for (int i = 0; i < NV; i++)
        begin
            wave_pos_next[i] = wave_pos_reg[i];
            if (cmd.tick && (req_reg.voice == tvws_pkg::VOICE_W'(i)))
            begin
                wave_pos_next[i] = wave_pos_reg[i] + tvws_pkg::WAVE_W'(1);
            end
            if (cmd.stop)
            begin
                wave_pos_next[i] = '0;
            end
        end
        if (cmd.step_adv)
        begin
            song_pos_next = pos_inc;
        end
        if (cmd.step_wrap || cmd.stop)
        begin
            song_pos_next = '0;
        end
        if (cmd.play)
        begin
            playing_next = 1'b1;
        end
        if (cmd.pause || cmd.stop)
        begin
            playing_next = 1'b0;
        end
    end

    // unwritten entries read as zero
    always_comb
    begin
        for (int i = 0; i < NV; i++)
        begin
            entry_period[i] = rd_hit_reg ? rd_data_reg[(NV - i) * PERIOD_W - 1 -: PERIOD_W]
                                         : '0;
        end
    end

    // mixer front end: sum and count of the active voices
    always_comb
    begin
        sum_next = '0;
        cnt_next = '0;
        for (int i = 0; i < NV; i++)
        begin
            if (entry_period[i] != '0)
            begin
                sum_next = sum_next + SUM_W'(tvws_pkg::sine_value(wave_pos_reg[i]));
                cnt_next = cnt_next + tvws_pkg::CNT_W'(1);
            end
        end
    end

    // average: count 3 uses a reciprocal multiply
    assign prod = tvws_pkg::PROD_W'(sum_reg) * tvws_pkg::PROD_W'(tvws_pkg::RECIP_THREE);

    always_comb
    begin
        case (cnt_reg)
            2'd1:    quot = sum_reg;
            2'd2:    quot = sum_reg >> 1;
            2'd3:    quot = prod[tvws_pkg::RECIP_SHIFT +: SUM_W];
            default: quot = '0;
        endcase
        if (mute_reg)
        begin
            quot = '0;
        end
    end

    always_comb
    begin
        rsp_next             = '0;
        rsp_next.result_kind = kind_reg;
        if (kind_reg == tvws_pkg::KIND_RELOAD)
        begin
            rsp_next.reload_one   = entry_period[0];
            rsp_next.reload_two   = entry_period[1];
            rsp_next.reload_three = entry_period[2];
        end
        else
        begin
            rsp_next.sample = quot[tvws_pkg::SAMPLE_W-1:0];
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            song_len_reg  <= '0;
            playing_reg   <= 1'b0;
            song_pos_reg  <= '0;
            valid_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < NV; i++)
            begin
                wave_pos_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                song_len_reg <= cfg_data;
            end
            playing_reg   <= playing_next;
            song_pos_reg  <= song_pos_next;
            rsp_valid_reg <= rsp_valid_next;
            for (int i = 0; i < NV; i++)
            begin
                wave_pos_reg[i] <= wave_pos_next[i];
            end
            if (cmd.write_entry && wr_in_range)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
        end
    end

    // song table, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.write_entry && wr_in_range)
        begin
            song_mem[wr_idx] <= {req_reg.period_one, req_reg.period_two, req_reg.period_three};
        end
        if (rd_en)
        begin
            rd_data_reg <= song_mem[rd_idx];
            rd_hit_reg  <= rd_in_range && valid_reg[rd_idx];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req;
        end
        if (cmd.step_adv)
        begin
            kind_reg <= tvws_pkg::KIND_RELOAD;
        end
        if (cmd.tick)
        begin
            kind_reg <= tvws_pkg::KIND_SAMPLE;
        end
        if (cmd.mix)
        begin
            sum_reg  <= sum_next;
            cnt_reg  <= cnt_next;
            mute_reg <= !playing_reg;
        end
        if (cmd.out_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule
